// File: hw/rtl/maze_cell_opening_encoder_assert.svh
// ----------------------------------------------------------------------------
// Maze cell opening encoder assertion macros
// Concurrent check forms clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MAZE_CELL_OPENING_ENCODER_ASSERT_SVH
`define MAZE_CELL_OPENING_ENCODER_ASSERT_SVH

// same-cycle implication
`define MCEO_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("maze cell encoder check failed");

// next-cycle implication
`define MCEO_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("maze cell encoder check failed");

`endif

// File: hw/rtl/mceo_pkg.sv
// ----------------------------------------------------------------------------
// Maze cell opening encoder package
// Widths, register codes and the cell word passed from front to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mceo_pkg;

    localparam int CHAR_W              = 8;
    localparam int COLUMN_W            = 11;
    localparam int ROW_W               = 16;
    localparam int OPEN_W              = 5;
    localparam int CELL_COL_W          = 10;
    localparam int CELL_ROW_W          = 15;
    localparam int CFG_INDEX_W         = 1;
    localparam int CFG_DATA_W          = 16;
    localparam int MAX_COLUMNS_DEFAULT = 2048;
    localparam int QUEUE_DEPTH         = 4;

    localparam logic [CHAR_W-1:0]   OPEN_CHAR          = 8'h20;
    localparam logic [COLUMN_W-1:0] COLUMN_COUNT_RESET = 11'd3;
    localparam logic [ROW_W-1:0]    ROW_COUNT_RESET    = 16'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_COLUMN_COUNT = 1'b0,
        REG_ROW_COUNT    = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [COLUMN_W-1:0]   col;
        logic                  cur_open;
        logic                  emit;
        logic                  east_ok;
        logic                  west_ok;
        logic                  store_ok;
        logic                  last;
        logic [CELL_COL_W-1:0] cell_col;
        logic [CELL_ROW_W-1:0] cell_row;
    } cell_desc_t;

    typedef struct packed {
        logic upper;
        logic middle;
    } mark_t;

endpackage

// File: hw/rtl/mceo_front.sv
// ----------------------------------------------------------------------------
// Maze cell opening encoder front end
// Holds configuration and text position, classifies each character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mceo_front #(
    parameter int MAX_COLUMNS = mceo_pkg::MAX_COLUMNS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [mceo_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mceo_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               char_valid,
    output logic                               char_stall,
    input  logic [mceo_pkg::CHAR_W-1:0]        maze_char,
    input  logic                               queue_full,
    output logic                               push,
    output mceo_pkg::cell_desc_t               push_desc
);
    import mceo_pkg::*;

    logic [COLUMN_W-1:0] column_count_reg;
    logic [ROW_W-1:0]    row_count_reg;
    logic [COLUMN_W-1:0] col_pos_reg;
    logic [COLUMN_W-1:0] col_pos_next;
    logic [ROW_W-1:0]    row_pos_reg;
    logic [ROW_W-1:0]    row_pos_next;

    logic [COLUMN_W:0]   col_inc;
    logic [COLUMN_W:0]   col_inc2;
    logic [ROW_W:0]      row_inc;
    logic [ROW_W:0]      row_inc2;
    logic                col_wrap;
    logic                row_wrap;

    assign char_stall = queue_full;
    assign push       = char_valid && !queue_full;

    assign col_inc  = (COLUMN_W+1)'(col_pos_reg) + (COLUMN_W+1)'(1);
    assign col_inc2 = (COLUMN_W+1)'(col_pos_reg) + (COLUMN_W+1)'(2);
    assign row_inc  = (ROW_W+1)'(row_pos_reg) + (ROW_W+1)'(1);
    assign row_inc2 = (ROW_W+1)'(row_pos_reg) + (ROW_W+1)'(2);
    assign col_wrap = col_inc >= (COLUMN_W+1)'(column_count_reg);
    assign row_wrap = row_inc >= (ROW_W+1)'(row_count_reg);

    always_comb
    begin
        col_pos_next = col_wrap ? '0 : col_inc[COLUMN_W-1:0];
        row_pos_next = row_pos_reg;
        if (col_wrap)
        begin
            row_pos_next = row_wrap ? '0 : row_inc[ROW_W-1:0];
        end
    end

    always_comb
    begin
        push_desc.col      = col_pos_reg;
        push_desc.cur_open = (maze_char == OPEN_CHAR);
        push_desc.emit     = (row_pos_reg >= ROW_W'(2)) && !row_pos_reg[0] && col_pos_reg[0];
        push_desc.east_ok  = !col_wrap && (32'(col_inc) < 32'(MAX_COLUMNS));
        push_desc.west_ok  = (col_pos_reg != '0);
        push_desc.store_ok = 32'(col_pos_reg) < 32'(MAX_COLUMNS);
        push_desc.last     = (row_inc2 >= (ROW_W+1)'(row_count_reg))
                          && (col_inc2 >= (COLUMN_W+1)'(column_count_reg));
        push_desc.cell_col = col_pos_reg[COLUMN_W-1:1];
        push_desc.cell_row = CELL_ROW_W'(row_pos_reg[ROW_W-1:1] - CELL_ROW_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= COLUMN_COUNT_RESET;
            row_count_reg    <= ROW_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COLUMN_COUNT: column_count_reg <= cfg_data[COLUMN_W-1:0];
                REG_ROW_COUNT:    row_count_reg    <= cfg_data[ROW_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else if (push)
        begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
        end
    end

endmodule

// File: hw/rtl/mceo_queue.sv
// ----------------------------------------------------------------------------
// Maze cell opening encoder word queue
// Short FIFO of classified character words between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mceo_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mceo_pkg::cell_desc_t  push_desc,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output mceo_pkg::cell_desc_t  head_desc
);
    import mceo_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cell_desc_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign full       = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/mceo_back.sv
// ----------------------------------------------------------------------------
// Maze cell opening encoder back end
// Line buffer of open marks, neighbor lookup, cell code and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mceo_back #(
    parameter int MAX_COLUMNS = mceo_pkg::MAX_COLUMNS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              head_valid,
    input  mceo_pkg::cell_desc_t              head_desc,
    output logic                              pop,
    output logic                              cell_valid,
    input  logic                              cell_stall,
    output logic [mceo_pkg::OPEN_W-1:0]       openings,
    output logic [mceo_pkg::CELL_COL_W-1:0]   cell_column,
    output logic [mceo_pkg::CELL_ROW_W-1:0]   cell_row,
    output logic                              last_cell
);
    import mceo_pkg::*;

    localparam int ADDR_W = $clog2(MAX_COLUMNS);

    mark_t               line_mem [MAX_COLUMNS];
    mark_t               rd0_reg;
    mark_t               rd1_reg;
    mark_t               fwd_mark_reg;
    logic                fwd0_reg;
    logic                fwd1_reg;
    cell_desc_t          b1_desc_reg;
    logic                b1_valid_reg;
    logic                b1_valid_next;
    logic                west_reg;
    logic                west_next;
    logic                cell_valid_reg;
    logic                cell_valid_next;
    logic [OPEN_W-1:0]   openings_reg;
    logic [OPEN_W-1:0]   openings_next;
    logic [CELL_COL_W-1:0] cell_column_reg;
    logic [CELL_ROW_W-1:0] cell_row_reg;
    logic                last_cell_reg;

    logic                out_free;
    logic                b1_adv;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    mark_t               wr_mark;
    logic [ADDR_W-1:0]   rd0_addr;
    logic [ADDR_W-1:0]   rd1_addr;
    mark_t               entry;
    logic                east_mid;
    logic                north;
    logic                east;
    logic                west;

    assign out_free = !cell_valid_reg || !cell_stall;
    assign b1_adv   = b1_valid_reg && (!b1_desc_reg.emit || out_free);
    assign pop      = head_valid && (!b1_valid_reg || b1_adv);

    assign rd0_addr = ADDR_W'(head_desc.col);
    assign rd1_addr = ADDR_W'((COLUMN_W+1)'(head_desc.col) + (COLUMN_W+1)'(1));

    assign entry    = fwd0_reg ? fwd_mark_reg : rd0_reg;
    assign east_mid = fwd1_reg ? fwd_mark_reg.middle : rd1_reg.middle;

    assign north = b1_desc_reg.store_ok && entry.upper;
    assign east  = b1_desc_reg.east_ok && east_mid;
    assign west  = b1_desc_reg.west_ok && west_reg;

    assign wr_en          = b1_adv && b1_desc_reg.store_ok;
    assign wr_addr        = ADDR_W'(b1_desc_reg.col);
    assign wr_mark.upper  = entry.middle;
    assign wr_mark.middle = b1_desc_reg.cur_open;

    assign openings_next   = {west, b1_desc_reg.cur_open, east, north, 1'b0};
    assign b1_valid_next   = pop ? 1'b1 : (b1_adv ? 1'b0 : b1_valid_reg);
    assign west_next       = b1_adv ? (b1_desc_reg.store_ok && entry.middle) : west_reg;
    assign cell_valid_next = (b1_adv && b1_desc_reg.emit) ? 1'b1
                           : (cell_stall ? cell_valid_reg : 1'b0);

    assign cell_valid  = cell_valid_reg;
    assign openings    = openings_reg;
    assign cell_column = cell_column_reg;
    assign cell_row    = cell_row_reg;
    assign last_cell   = last_cell_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_mark;
        end
        if (pop)
        begin
            rd0_reg <= line_mem[rd0_addr];
            rd1_reg <= line_mem[rd1_addr];
        end
    end

    // bypass the write that lands in the same cycle as the read
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b1_desc_reg  <= head_desc;
            fwd0_reg     <= wr_en && (wr_addr == rd0_addr);
            fwd1_reg     <= wr_en && (wr_addr == rd1_addr);
            fwd_mark_reg <= wr_mark;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b1_adv && b1_desc_reg.emit)
        begin
            openings_reg    <= openings_next;
            cell_column_reg <= b1_desc_reg.cell_col;
            cell_row_reg    <= b1_desc_reg.cell_row;
            last_cell_reg   <= b1_desc_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg   <= 1'b0;
            west_reg       <= 1'b0;
            cell_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg   <= b1_valid_next;
            west_reg       <= west_next;
            cell_valid_reg <= cell_valid_next;
        end
    end

endmodule

// File: hw/rtl/maze_cell_opening_encoder.sv
// ----------------------------------------------------------------------------
// Maze cell opening encoder: one character a cycle unless stalled.
// One cell code per cell, via queue, b1 stage and output register in order.
// Throughput: 1 character per cycle unless stalled, set by the 2R1W buffer.
// Reset: async, clears positions, queue, output; counts to 3; buffer kept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module maze_cell_opening_encoder #(
    parameter int MAX_COLUMNS = mceo_pkg::MAX_COLUMNS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [mceo_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mceo_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              char_valid,
    output logic                              char_stall,
    input  logic [mceo_pkg::CHAR_W-1:0]       maze_char,
    output logic                              cell_valid,
    input  logic                              cell_stall,
    output logic [mceo_pkg::OPEN_W-1:0]       openings,
    output logic [mceo_pkg::CELL_COL_W-1:0]   cell_column,
    output logic [mceo_pkg::CELL_ROW_W-1:0]   cell_row,
    output logic                              last_cell
);
    import mceo_pkg::*;

    logic       push;
    cell_desc_t push_desc;
    logic       queue_full;
    logic       pop;
    logic       head_valid;
    cell_desc_t head_desc;

    mceo_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .maze_char  (maze_char),
        .queue_full (queue_full),
        .push       (push),
        .push_desc  (push_desc)
    );

    mceo_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    mceo_back #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_desc   (head_desc),
        .pop         (pop),
        .cell_valid  (cell_valid),
        .cell_stall  (cell_stall),
        .openings    (openings),
        .cell_column (cell_column),
        .cell_row    (cell_row),
        .last_cell   (last_cell)
    );

endmodule

// File: hw/rtl/mceo_checker.sv
// ----------------------------------------------------------------------------
// Maze cell opening encoder port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "maze_cell_opening_encoder_assert.svh"

module mceo_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              char_stall,
    input logic                              cell_valid,
    input logic                              cell_stall,
    input logic [mceo_pkg::OPEN_W-1:0]       openings,
    input logic [mceo_pkg::CELL_COL_W-1:0]   cell_column,
    input logic [mceo_pkg::CELL_ROW_W-1:0]   cell_row,
    input logic                              last_cell
);
    import mceo_pkg::*;

    logic [OPEN_W+CELL_COL_W+CELL_ROW_W:0] held_word;

    assign held_word = {openings, cell_column, cell_row, last_cell};

    `MCEO_ASSERT_IMP(a_open_low_bit_zero, cell_valid, !openings[0])
    `MCEO_ASSERT_IMP(a_ready_after_reset, $past(!rst_n), !char_stall)
    `MCEO_ASSERT_NXT(a_valid_holds, cell_valid && cell_stall, cell_valid)
    `MCEO_ASSERT_NXT(a_word_holds, cell_valid && cell_stall, $stable(held_word))

endmodule

bind maze_cell_opening_encoder mceo_checker u_checker (.*);

// File: tb/tb_maze_cell_opening_encoder.sv
// ----------------------------------------------------------------------------
// Maze cell opening encoder testbench
// Streams text mazes through the encoder under random source gaps and sink
// stalls. A line-buffer model inside the bench predicts the untyped cell words,
// a scoreboard checks each word field by field in order. Directed rows cover
// byte extremes, all-open cells and a missing east neighbour. Further phases
// cover a wide row, a very tall row count cut short, and many small mazes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_maze_cell_opening_encoder;

    import mceo_pkg::*;

    typedef struct packed {
        logic [OPEN_W-1:0]     openings;
        logic [CELL_COL_W-1:0] column;
        logic [CELL_ROW_W-1:0] row;
        logic                  last;
    } cell_t;

    typedef struct packed {
        logic                  is_cfg;
        cfg_reg_t              sel;
        logic [CFG_DATA_W-1:0] value;
        logic                  typed;
        cell_t                 result;
    } step_t;

    localparam int N_DIRECTED    = 24;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_AT       = 100;
    localparam int HOLD_CYCLES   = 100;
    localparam int RANDOM_CHARS  = 250;
    localparam int TALL_ROWS     = 40;
    localparam int WIDE_COLUMNS  = 255;

    localparam logic [CHAR_W-1:0] WALL_CHAR = 8'h23;

    localparam step_t DIRECTED_STEPS [N_DIRECTED] = '{
        '{1'b1, REG_COLUMN_COUNT, 16'hF803, 1'b0, '0},
        '{1'b1, REG_ROW_COUNT,    16'd3,    1'b0, '0},
        '{1'b0, REG_COLUMN_COUNT, 16'h0000, 1'b0, '0},
        '{1'b0, REG_COLUMN_COUNT, 16'h00FF, 1'b0, '0},
        '{1'b0, REG_COLUMN_COUNT, 16'h0021, 1'b0, '0},
        '{1'b0, REG_COLUMN_COUNT, 16'h001F, 1'b0, '0},
        '{1'b0, REG_COLUMN_COUNT, 16'h00A0, 1'b0, '0},
        '{1'b0, REG_COLUMN_COUNT, 16'h007F, 1'b0, '0},
        '{1'b0, REG_COLUMN_COUNT, 16'h0080, 1'b0, '0},
        '{1'b0, REG_COLUMN_COUNT, 16'h0001, 1'b1, '{5'd0, 10'd0, 15'd0, 1'b1}},
        '{1'b0, REG_COLUMN_COUNT, 16'h0040, 1'b0, '0},
        '{1'b1, REG_COLUMN_COUNT, 16'd4,    1'b0, '0},
        '{1'b0, REG_COLUMN_COUNT, 16'h0020, 1'b0, '0},
        '{1'b0, REG_COLUMN_COUNT, 16'h0020, 1'b0, '0},
        '{1'b0, REG_COLUMN_COUNT, 16'h0020, 1'b0, '0},
        '{1'b0, REG_COLUMN_COUNT, 16'h0020, 1'b0, '0},
        '{1'b0, REG_COLUMN_COUNT, 16'h0020, 1'b0, '0},
        '{1'b0, REG_COLUMN_COUNT, 16'h0020, 1'b0, '0},
        '{1'b0, REG_COLUMN_COUNT, 16'h0020, 1'b0, '0},
        '{1'b0, REG_COLUMN_COUNT, 16'h0020, 1'b0, '0},
        '{1'b0, REG_COLUMN_COUNT, 16'h0020, 1'b0, '0},
        '{1'b0, REG_COLUMN_COUNT, 16'h0020, 1'b1, '{5'd30, 10'd0, 15'd0, 1'b0}},
        '{1'b0, REG_COLUMN_COUNT, 16'h0020, 1'b0, '0},
        '{1'b0, REG_COLUMN_COUNT, 16'h0020, 1'b1, '{5'd26, 10'd1, 15'd0, 1'b1}}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  char_valid;
    logic                  char_stall;
    logic [CHAR_W-1:0]     maze_char;
    logic                  cell_valid;
    logic                  cell_stall;
    logic [OPEN_W-1:0]     openings;
    logic [CELL_COL_W-1:0] cell_column;
    logic [CELL_ROW_W-1:0] cell_row;
    logic                  last_cell;

    logic               upper_mark [MAX_COLUMNS_DEFAULT];
    logic               middle_mark [MAX_COLUMNS_DEFAULT];
    logic               west_mark;
    logic [COLUMN_W-1:0] col_pos;
    logic [COLUMN_W-1:0] col_total;
    logic [ROW_W-1:0]    row_pos;
    logic [ROW_W-1:0]    row_total;

    cell_t pending_cells [$];
    int    mismatches   = 0;
    int    cells_seen   = 0;
    int    chars_taken  = 0;
    int    settings_run = 0;
    bit    quiet        = 1'b0;
    int    stall_left   = 0;
    int    hold_left    = 0;

    maze_cell_opening_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .maze_char   (maze_char),
        .cell_valid  (cell_valid),
        .cell_stall  (cell_stall),
        .openings    (openings),
        .cell_column (cell_column),
        .cell_row    (cell_row),
        .last_cell   (last_cell)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("%0t: timeout with %0d cells pending", $time, pending_cells.size());
        $display("Regression FAIL");
        $finish;
    end

    task automatic encode_char(input logic [CHAR_W-1:0] ch, output bit hit,
                               output cell_t word);
        int unsigned c;
        int unsigned r;
        logic        cur;
        logic        east;
        c    = col_pos;
        r    = row_pos;
        cur  = (ch == OPEN_CHAR);
        word = '0;
        hit  = (r >= 2) && !r[0] && c[0];
        if (hit)
        begin
            east = (c + 1 < col_total) ? middle_mark[c + 1] : 1'b0;
            // bit weights: N=2, E=4, S=8, W=16
            word.openings = {west_mark, cur, east, upper_mark[c], 1'b0};
            word.column   = CELL_COL_W'((c - 1) / 2);
            word.row      = CELL_ROW_W'((r - 1) / 2);
            word.last     = (r + 2 >= row_total) && (c + 2 >= col_total);
        end
        west_mark      = middle_mark[c];
        upper_mark[c]  = middle_mark[c];
        middle_mark[c] = cur;
        if (c + 1 >= col_total)
        begin
            col_pos   = '0;
            west_mark = 1'b0;
            row_pos   = (r + 1 >= row_total) ? '0 : row_pos + 1'b1;
        end
        else
        begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    function automatic logic [CHAR_W-1:0] random_char();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return OPEN_CHAR;
        if (pick < 9)
            return WALL_CHAR;
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] ch, input bit typed,
                             input cell_t typed_cell);
        int    gap;
        bit    hit;
        cell_t word;
        gap = quiet ? 0 : $urandom_range(0, 3);
        repeat (gap)
        begin
            @(negedge clk);
            char_valid <= 1'b0;
        end
        @(negedge clk);
        char_valid <= 1'b1;
        maze_char  <= ch;
        do
            @(posedge clk);
        while (char_stall);
        chars_taken++;
        encode_char(ch, hit, word);
        if (hit)
            pending_cells.push_back(typed ? typed_cell : word);
    endtask

    // drop valid, drain the scoreboard, then let the pipeline empty
    task automatic settle();
        @(negedge clk);
        char_valid <= 1'b0;
        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (sel == REG_COLUMN_COUNT)
            col_total = value[COLUMN_W-1:0];
        else
            row_total = value[ROW_W-1:0];
    endtask

    task automatic new_setting(input int columns, input int rows);
        settle();
        write_reg(REG_COLUMN_COUNT, CFG_DATA_W'(columns));
        write_reg(REG_ROW_COUNT, CFG_DATA_W'(rows));
        settings_run++;
        quiet = ($urandom_range(0, 3) == 0);
    endtask

    task automatic feed_maze();
        do
            send_char(random_char(), 1'b0, '0);
        while (col_pos != '0 || row_pos != '0);
    endtask

    initial
    begin
        cell_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && cell_valid && !cell_stall)
            begin
                cell_t want;
                cells_seen++;
                if (pending_cells.size() == 0)
                begin
                    $display("%0t: cell word with none pending, got %0d/%0d/%0d/%0d",
                             $time, openings, cell_column, cell_row, last_cell);
                    mismatches++;
                end
                else
                begin
                    want = pending_cells.pop_front();
                    if (openings !== want.openings)
                    begin
                        $display("%0t: openings expected %0d got %0d",
                                 $time, want.openings, openings);
                        mismatches++;
                    end
                    if (cell_column !== want.column)
                    begin
                        $display("%0t: cell_column expected %0d got %0d",
                                 $time, want.column, cell_column);
                        mismatches++;
                    end
                    if (cell_row !== want.row)
                    begin
                        $display("%0t: cell_row expected %0d got %0d",
                                 $time, want.row, cell_row);
                        mismatches++;
                    end
                    if (last_cell !== want.last)
                    begin
                        $display("%0t: last_cell expected %0d got %0d",
                                 $time, want.last, last_cell);
                        mismatches++;
                    end
                end
                stall_left = quiet ? 0 : $urandom_range(0, 3);
                if (cells_seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                cell_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                cell_stall <= 1'b1;
            end
            else
            begin
                cell_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int    start_chars;
        step_t step;
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = REG_COLUMN_COUNT;
        cfg_data   = '0;
        char_valid = 1'b0;
        maze_char  = '0;
        col_total  = COLUMN_COUNT_RESET;
        row_total  = ROW_COUNT_RESET;
        col_pos    = '0;
        row_pos    = '0;
        west_mark  = 1'b0;
        for (int i = 0; i < MAX_COLUMNS_DEFAULT; i++)
        begin
            upper_mark[i]  = 1'b0;
            middle_mark[i] = 1'b0;
        end
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            step = DIRECTED_STEPS[i];
            if (step.is_cfg)
            begin
                settle();
                write_reg(step.sel, step.value);
            end
            else
            begin
                send_char(step.value[CHAR_W-1:0], step.typed, step.result);
            end
        end

        // tall setting, cut short by lowering the row count mid-maze
        new_setting(3, 65535);
        repeat (TALL_ROWS * 3) send_char(random_char(), 1'b0, '0);
        settle();
        write_reg(REG_ROW_COUNT, CFG_DATA_W'(5));
        feed_maze();

        new_setting(WIDE_COLUMNS, 3);
        feed_maze();

        start_chars = chars_taken;
        while (chars_taken - start_chars < RANDOM_CHARS)
        begin
            new_setting($urandom_range(3, 14), $urandom_range(3, 12));
            feed_maze();
        end

        settle();
        $display("Checked %0d cell words from %0d characters over %0d maze settings",
                 cells_seen, chars_taken, settings_run);
        $display("Included %0d-column rows, a 65535-row setting and a long sink hold-off",
                 WIDE_COLUMNS);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
